// ===== design/wti_pkg.sv =====
// Shared types, constants and codes of the windowed trapezoid integrator.
`timescale 1ns / 1ps

package wti_pkg;

	// Ring depth and index width
	localparam int ENTRIES = 10;
	localparam int IDX_W   = $clog2(ENTRIES);

	// Field widths
	localparam int CMD_W    = 2;
	localparam int TIME_W   = 32;
	localparam int DIST_W   = 16;
	localparam int SAMPLE_W = 10;
	localparam int AREA_W   = 22;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Pair sum and product widths
	localparam int AB_W   = SAMPLE_W + 1;
	localparam int PROD_W = AB_W + TIME_W;

	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0]    MIN_INTERVAL_RST = 16'd50;
	localparam logic [CFG_W-1:0]    WINDOW_RST       = 16'd1000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT_RST = 10'd1000;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 2'd2;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic add_en;
		logic clear_en;
		logic query_start;
		logic walk_step;
		logic pair_en;
	} ctl_t;

endpackage

// ===== design/wti_ctrl.sv =====
// Controller state machine of the windowed trapezoid integrator.
`timescale 1ns / 1ps

module wti_ctrl import wti_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] command,
	output logic             busy,
	output logic             done,
	output ctl_t             ctl
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		busy    = 1'b1;
		done    = 1'b0;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					unique case (command)
						CMD_ADD:   ctl.add_en = 1'b1;
						CMD_CLEAR: ctl.clear_en = 1'b1;
						CMD_QUERY: begin
							ctl.query_start = 1'b1;
							cnt_d           = '0;
							state_d         = ST_WALK;
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				// Read one entry per cycle; pairs begin with the second entry
				ctl.walk_step = 1'b1;
				ctl.pair_en   = (cnt_q != '0);
				cnt_d         = cnt_q + IDX_W'(1);
				if (cnt_q == IDX_W'(ENTRIES - 1)) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: state_d = ST_DONE;
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== design/wti_datapath.sv =====
// Sample ring, configuration registers and pair accumulation pipeline.
`timescale 1ns / 1ps

module wti_datapath import wti_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_t                 ctl,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic [DIST_W-1:0]    distance,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic [AREA_W-1:0]    area_sum
);

	logic [CFG_W-1:0]    min_interval_q;
	logic [CFG_W-1:0]    window_q;
	logic [SAMPLE_W-1:0] sample_limit_q;

	logic [SAMPLE_W-1:0] sample_q [ENTRIES];
	logic [TIME_W-1:0]   time_q [ENTRIES];
	logic [IDX_W-1:0]    wr_idx_q;
	logic [TIME_W-1:0]   last_accept_q;

	logic [IDX_W-1:0]    ptr_q;
	logic [TIME_W-1:0]   limit_q;
	logic [SAMPLE_W-1:0] prev_sample_q;
	logic [TIME_W-1:0]   prev_time_q;

	logic                pv_s1, pv_s2;
	logic [AB_W-1:0]     ab_s1;
	logic [TIME_W-1:0]   dt_s1;
	logic [PROD_W-1:0]   prod_s2;
	logic [AREA_W-1:0]   sum_q;

	logic [TIME_W-1:0]   earliest;
	logic                add_ok;
	logic [SAMPLE_W-1:0] clamped;
	logic [IDX_W-1:0]    wr_next;
	logic [IDX_W-1:0]    ptr_next;
	logic [SAMPLE_W-1:0] cur_sample;
	logic [TIME_W-1:0]   cur_time;
	logic                pair_ok;
	logic [AREA_W:0]     sum_wide;
	logic [AREA_W-1:0]   sum_next;

	// Interval test and clamp for add
	assign earliest = last_accept_q + TIME_W'(min_interval_q);
	assign add_ok   = (last_accept_q == '0) || (now_ms >= earliest);
	assign clamped  = (distance > DIST_W'(sample_limit_q)) ? sample_limit_q
		: distance[SAMPLE_W-1:0];
	assign wr_next  = (wr_idx_q == IDX_W'(ENTRIES - 1)) ? '0 : wr_idx_q + IDX_W'(1);
	assign ptr_next = (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : ptr_q + IDX_W'(1);

	// Current walk entry and pair qualification
	assign cur_sample = sample_q[ptr_q];
	assign cur_time   = time_q[ptr_q];
	assign pair_ok    = ctl.pair_en && (prev_time_q >= limit_q) && (cur_time > prev_time_q);

	// Saturating accumulate
	always_comb begin
		sum_wide = {1'b0, sum_q} + {1'b0, prod_s2[AREA_W-1:0]};
		if ((prod_s2 > PROD_W'(AREA_MAX)) || sum_wide[AREA_W]) begin
			sum_next = AREA_MAX;
		end else begin
			sum_next = sum_wide[AREA_W-1:0];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= MIN_INTERVAL_RST;
			window_q       <= WINDOW_RST;
			sample_limit_q <= SAMPLE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_INTERVAL: min_interval_q <= cfg_data;
				REG_WINDOW:       window_q <= cfg_data;
				REG_SAMPLE_LIMIT: sample_limit_q <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample ring: add writes one slot, clear zeroes all slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				sample_q[i] <= '0;
				time_q[i]   <= '0;
			end
			wr_idx_q      <= '0;
			last_accept_q <= '0;
		end else if (ctl.clear_en) begin
			for (int i = 0; i < ENTRIES; i++) begin
				sample_q[i] <= '0;
				time_q[i]   <= '0;
			end
		end else if (ctl.add_en && add_ok) begin
			sample_q[wr_idx_q] <= clamped;
			time_q[wr_idx_q]   <= now_ms;
			wr_idx_q           <= wr_next;
			last_accept_q      <= now_ms;
		end
	end

	// Walk pointer, age limit and previous entry
	always_ff @(posedge clk) begin
		if (ctl.query_start) begin
			ptr_q   <= wr_idx_q;
			limit_q <= now_ms - TIME_W'(window_q);
		end else if (ctl.walk_step) begin
			ptr_q         <= ptr_next;
			prev_sample_q <= cur_sample;
			prev_time_q   <= cur_time;
		end
	end

	// Pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
		end else begin
			pv_s1 <= ctl.walk_step && pair_ok;
			pv_s2 <= pv_s1;
		end
	end

	// Stage 1 operands, stage 2 product, then accumulate
	always_ff @(posedge clk) begin
		ab_s1   <= AB_W'(prev_sample_q) + AB_W'(cur_sample);
		dt_s1   <= cur_time - prev_time_q;
		prod_s2 <= ab_s1 * dt_s1;
		if (ctl.query_start) begin
			sum_q <= '0;
		end else if (pv_s2) begin
			sum_q <= sum_next;
		end
	end

	assign area_sum = sum_q;

endmodule

// ===== design/windowed_trapezoid_integrator_core.sv =====
// Top level of the windowed trapezoid integrator: controller, datapath and checks.
`timescale 1ns / 1ps
//
// Usage:
//   A command transfers at a rising edge with start high and busy low.
//   command selects add sample, query integral or clear store; now_ms is the
//   tick time of the command and distance the raw sample for add.
//   Add and clear finish at the transfer edge and produce no result; busy
//   stays low, so the next command may follow in the next cycle.
//   A query walks all ENTRIES ring entries one entry per cycle, then the
//   operand and multiplier stages fill. done pulses for one cycle with
//   area_sum valid; busy is high from the transfer until the cycle after
//   done, so no new command transfers while a query is in progress.
//   The receiver cannot stall: the result is taken in the done cycle.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data),
//   written while busy is low and no query is in progress.
//   Reset (arst_n low) clears the ring, the write index, the last accept
//   time and the controller, and loads the register defaults.
//
module windowed_trapezoid_integrator_core import wti_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     command,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic [DIST_W-1:0]    distance,
	output logic                 done,
	output logic [AREA_W-1:0]    area_sum,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	ctl_t ctl;

	// Sequence the commands
	wti_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.busy    (busy),
		.done    (done),
		.ctl     (ctl)
	);

	// Store samples and accumulate pairs
	wti_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.now_ms    (now_ms),
		.distance  (distance),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.area_sum  (area_sum)
	);

`ifndef NO_ASSERTIONS
	// A query transfer produces its result after a fixed latency
	a_query_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_QUERY) |-> ##(ENTRIES + 3) done)
		else $error("query result not delivered at expected latency");

	// The result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// Add and clear never start a walk
	a_no_walk_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_ADD || command == CMD_CLEAR)) |=> !busy)
		else $error("add or clear made the block busy");
`endif

endmodule

// ===== test/windowed_trapezoid_integrator_core_tb.sv =====
// Self-checking testbench of the windowed trapezoid integrator core.
`timescale 1ns / 1ps

module windowed_trapezoid_integrator_core_tb;
	import wti_pkg::*;

	// Spare command code that the block must ignore
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = ENTRIES + 6;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [CMD_W-1:0]     command;
	logic [TIME_W-1:0]    now_ms;
	logic [DIST_W-1:0]    distance;
	logic                 done;
	logic [AREA_W-1:0]    area_sum;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Shadow of the block: ring, write pointer, last accept time, registers
	logic [SAMPLE_W-1:0] ring_dist [ENTRIES];
	logic [TIME_W-1:0]   ring_time [ENTRIES];
	int unsigned         ring_wr;
	logic [TIME_W-1:0]   last_take;
	logic [CFG_W-1:0]    min_gap_ms;
	logic [CFG_W-1:0]    window_len_ms;
	logic [SAMPLE_W-1:0] dist_cap;

	// Areas still owed by queries already transferred
	logic [AREA_W-1:0] pending_areas [$];

	int          fail_cnt;
	int unsigned cycle_cnt;
	bit          idle_on;
	logic [TIME_W-1:0] t_cursor;

	windowed_trapezoid_integrator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.now_ms    (now_ms),
		.distance  (distance),
		.done      (done),
		.area_sum  (area_sum),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Restore the shadow to its power-on contents
	function automatic void shadow_reset();
		for (int i = 0; i < ENTRIES; i++) begin
			ring_dist[i] = '0;
			ring_time[i] = '0;
		end
		ring_wr       = 0;
		last_take     = '0;
		min_gap_ms    = MIN_INTERVAL_RST;
		window_len_ms = WINDOW_RST;
		dist_cap      = SAMPLE_LIMIT_RST;
	endfunction

	// Store a clamped sample unless it falls inside the minimum interval
	function automatic void store_sample(input logic [TIME_W-1:0] now,
			input logic [DIST_W-1:0] raw_dist);
		logic [TIME_W-1:0]   earliest;
		logic [SAMPLE_W-1:0] kept;
		earliest = now - now + last_take + {16'd0, min_gap_ms};
		if (last_take != '0 && now < earliest)
			return;
		kept = (raw_dist > {6'd0, dist_cap}) ? dist_cap : raw_dist[SAMPLE_W-1:0];
		last_take = now;
		ring_dist[ring_wr] = kept;
		ring_time[ring_wr] = now;
		ring_wr = (ring_wr + 1) % ENTRIES;
	endfunction

	// Trapezoid sum over recent, time-ordered neighbor pairs, saturating
	function automatic logic [AREA_W-1:0] trapezoid_area(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] floor_t;
		logic [TIME_W-1:0] dt32;
		logic [63:0]       acc;
		logic [63:0]       pair_ab;
		logic [63:0]       pair_dt;
		int                o;
		int                n;
		floor_t = now - {16'd0, window_len_ms};
		acc = '0;
		o = ring_wr;
		for (int i = 0; i < ENTRIES - 1; i++) begin
			n = (o + 1) % ENTRIES;
			if (ring_time[o] >= floor_t && ring_time[n] > ring_time[o]) begin
				dt32 = ring_time[n] - ring_time[o];
				pair_dt = {32'd0, dt32};
				pair_ab = {54'd0, ring_dist[o]} + {54'd0, ring_dist[n]};
				acc = acc + pair_ab * pair_dt;
				if (acc > {42'd0, AREA_MAX})
					acc = {42'd0, AREA_MAX};
			end
			o = n;
		end
		return acc[AREA_W-1:0];
	endfunction

	// Advance the shadow by one transferred command
	function automatic void apply_command(input logic [CMD_W-1:0] cmd,
			input logic [TIME_W-1:0] now, input logic [DIST_W-1:0] raw_dist);
		case (cmd)
			CMD_ADD: store_sample(now, raw_dist);
			CMD_QUERY: pending_areas.push_back(trapezoid_area(now));
			CMD_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++) begin
					ring_dist[i] = '0;
					ring_time[i] = '0;
				end
			end
			default: ;
		endcase
	endfunction

	// Present one command after a random gap when idle gaps are on, and hold it until it transfers
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
			input logic [DIST_W-1:0] raw_dist);
		int gap;
		gap = idle_on ? $urandom_range(0, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    = 1'b1;
		command  = cmd;
		now_ms   = now;
		distance = raw_dist;
		do
			@(posedge clk);
		while (busy);
		apply_command(cmd, now, raw_dist);
	endtask

	// Drop start and let every owed result arrive, then let the block settle
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_areas.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write on the configuration port
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		case (idx)
			REG_MIN_INTERVAL: min_gap_ms = value;
			REG_WINDOW: window_len_ms = value;
			REG_SAMPLE_LIMIT: dist_cap = value[SAMPLE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Edge cases at the reset register values
	task automatic test_directed_cases();
		idle_on = 1'b1;
		send_cmd(CMD_QUERY, 32'd0, 16'd0);
		send_cmd(CMD_ADD, 32'd0, 16'hFFFF);
		send_cmd(CMD_ADD, 32'd5, 16'd0);
		send_cmd(CMD_ADD, 32'd20, 16'd300);
		send_cmd(CMD_ADD, 32'd55, 16'd1023);
		send_cmd(CMD_QUERY, 32'd100, 16'd0);
		send_cmd(CMD_ADD, 32'd3055, 16'd1000);
		send_cmd(CMD_QUERY, 32'd1000, 16'd0);
		send_cmd(CMD_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF);
		send_cmd(CMD_QUERY, 32'd1000, 16'd0);
		send_cmd(CMD_CLEAR, 32'd0, 16'd0);
		send_cmd(CMD_QUERY, 32'd1000, 16'd0);
		// last accept time survives the clear
		send_cmd(CMD_ADD, 32'd3060, 16'd7);
		send_cmd(CMD_ADD, 32'hFFFF_FFF0, 16'd512);
		// earliest time wraps past zero, so this one lands out of order
		send_cmd(CMD_ADD, 32'h0000_0030, 16'd511);
		send_cmd(CMD_QUERY, 32'hFFFF_FFFF, 16'd0);
		send_cmd(CMD_ADD, 32'h0000_0100, 16'h5555);
		send_cmd(CMD_ADD, 32'h0000_0200, 16'hAAAA);
		send_cmd(CMD_QUERY, 32'h0000_0300, 16'd0);
		send_cmd(CMD_UNKNOWN, 32'd0, 16'd0);
		t_cursor = 32'h0000_0400;
		wait_idle();
	endtask

	// Mostly advancing adds with queries near the current time, plus noise
	task automatic run_random_items(input int count);
		int                sel;
		int                r;
		logic [TIME_W-1:0] q_now;
		logic [DIST_W-1:0] raw_dist;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 15) == 0)
				idle_on = !idle_on;
			sel = $urandom_range(0, 99);
			r   = $urandom_range(0, 9);
			raw_dist = ($urandom_range(0, 1) == 0) ? DIST_W'($urandom()) :
				DIST_W'($urandom_range(0, int'(dist_cap)));
			if (sel < 65) begin
				if (r < 7)
					t_cursor = t_cursor + min_gap_ms +
						$urandom_range(0, 60 + int'(window_len_ms) / 8);
				else if (r < 9)
					t_cursor = t_cursor + $urandom_range(0, int'(min_gap_ms));
				else
					t_cursor = $urandom();
				send_cmd(CMD_ADD, t_cursor, raw_dist);
			end else if (sel < 92) begin
				if (r < 6)
					q_now = t_cursor + $urandom_range(0, int'(window_len_ms));
				else if (r < 9)
					q_now = t_cursor - $urandom_range(0, 500);
				else
					q_now = $urandom();
				send_cmd(CMD_QUERY, q_now, DIST_W'($urandom()));
			end else if (sel < 96) begin
				send_cmd(CMD_CLEAR, $urandom(), DIST_W'($urandom()));
			end else begin
				send_cmd(CMD_UNKNOWN, $urandom(), DIST_W'($urandom()));
			end
		end
		wait_idle();
	endtask

	// Random traffic at the reset register values
	task automatic test_random_defaults();
		run_random_items(250);
	endtask

	// Random traffic across register settings, extremes included
	task automatic test_register_sweep();
		logic [CFG_W-1:0]    gap_set [7];
		logic [CFG_W-1:0]    win_set [7];
		logic [SAMPLE_W-1:0] cap_set [7];
		gap_set = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd50, 16'd0, 16'd0};
		win_set = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd1000, 16'd0, 16'd0};
		cap_set = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1000, 10'd0, 10'd0};
		for (int p = 0; p < 7; p++) begin
			if (p >= 5) begin
				gap_set[p] = CFG_W'($urandom_range(0, 300));
				win_set[p] = CFG_W'($urandom());
				cap_set[p] = SAMPLE_W'($urandom());
			end
			write_reg(REG_MIN_INTERVAL, gap_set[p]);
			write_reg(REG_WINDOW, win_set[p]);
			write_reg(REG_SAMPLE_LIMIT, {6'd0, cap_set[p]});
			run_random_items(250);
		end
	endtask

	// Compare each area with the oldest owed one
	always @(posedge clk) begin : check_area
		logic [AREA_W-1:0] want;
		if (arst_n && done) begin
			if (pending_areas.size() == 0) begin
				$error("area_sum: expected none, actual %0d", area_sum);
				fail_cnt++;
			end else begin
				want = pending_areas.pop_front();
				if (area_sum !== want) begin
					$error("area_sum: expected %0d, actual %0d", want, area_sum);
					fail_cnt++;
				end
			end
		end
	end

	// Stop a hung run
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("windowed_trapezoid_integrator_core_tb NOT OK");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		command   = CMD_ADD;
		now_ms    = '0;
		distance  = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_MIN_INTERVAL;
		cfg_data  = '0;
		fail_cnt  = 0;
		idle_on   = 1'b1;
		t_cursor  = '0;
		shadow_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_defaults();
		test_register_sweep();

		if (fail_cnt == 0)
			$display("windowed_trapezoid_integrator_core_tb OK");
		else
			$display("windowed_trapezoid_integrator_core_tb NOT OK");
		$finish;
	end

endmodule
